// ===== rtl/dstat_pkg.sv =====
// shared widths, codes and control structs for the duration statistics core
package dstat_pkg;

    localparam int TIME_WIDTH  = 64;
    localparam int COUNT_WIDTH = 32;
    localparam int BIT_CNT_W   = $clog2(TIME_WIDTH);

    localparam int OUT_TIME_W  = 64;
    localparam int OUT_COUNT_W = 32;
    localparam int S_TDATA_W   = 64;
    localparam int M_TDATA_W   = 4 * OUT_TIME_W + OUT_COUNT_W;

    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_STOP  = 1'b1;

    typedef logic [TIME_WIDTH-1:0]  time_t;
    typedef logic [COUNT_WIDTH-1:0] count_t;

    typedef struct packed {
        logic start_wr;
        logic pass_load;
        logic pass_step;
        logic pass_end;
    } acc_ctrl_t;

    typedef struct packed {
        logic load;
        logic step;
    } div_ctrl_t;

endpackage

// ===== rtl/duration_min_max_mean_stats_core.sv =====
// top level of the duration min/max/mean statistics core
//
// input stream: s_tuser is the mark kind (0 start, 1 stop), s_tdata the 64-bit
// timestamp in ns. a start transfer stores the timestamp and gives no
// result. a stop transfer measures stop minus start, updates
// minimum, maximum, sample count and duration sum, and gives one result
// transfer with the truncated mean, min, max, count and the last duration;
// m_tuser flags a saturated sum or count.
// handling of a stop: the bit-serial subtract/compare/add pass, an update
// step, a divider load and the restoring divider run, then the result
// register loads and m_tvalid is set with it.
// throughput: one start per cycle while the core is idle; a stop holds off
// further marks until its result has been loaded into the result register.
// s_tready is low while a stop is being worked on. the result register holds
// its transfer while m_tready is low; start marks are still taken then, and a
// following stop waits after its division until the result is taken.
// reset (aresetn, synchronous, active low) clears start time, sum, count,
// maximum and the saturation flag, sets the minimum to all ones and drops
// m_tvalid.
module duration_min_max_mean_stats_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [dstat_pkg::S_TDATA_W-1:0]  s_tdata,   // timestamp
    input  logic                             s_tuser,   // func
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [dstat_pkg::M_TDATA_W-1:0]  m_tdata,   // mean, min, max, samples, last
    output logic                             m_tuser    // saturated
);
    import dstat_pkg::*;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_SERIAL  = 3'd1;
    localparam logic [2:0] ST_UPDATE  = 3'd2;
    localparam logic [2:0] ST_DIVLOAD = 3'd3;
    localparam logic [2:0] ST_DIVIDE  = 3'd4;
    localparam logic [2:0] ST_OUTPUT  = 3'd5;

    localparam logic [BIT_CNT_W-1:0] LAST_BIT = BIT_CNT_W'(TIME_WIDTH - 1);

    logic [2:0]           state_reg;
    logic [2:0]           state_next;
    logic [BIT_CNT_W-1:0] bit_cnt_reg;
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 m_tuser_reg;

    acc_ctrl_t acc_ctrl;
    div_ctrl_t div_ctrl;
    time_t     stamp;
    time_t     dur;
    time_t     min_val;
    time_t     max_val;
    time_t     sum_val;
    time_t     quotient;
    count_t    count_val;
    logic      ovf;
    logic      s_xfer;
    logic      out_load;

    assign stamp    = s_tdata[TIME_WIDTH-1:0];
    assign s_tready = (state_reg == ST_IDLE);
    assign s_xfer   = s_tvalid & s_tready;
    assign out_load = (state_reg == ST_OUTPUT) & (~m_tvalid_reg | m_tready);

    always_comb begin
        acc_ctrl           = '0;
        div_ctrl           = '0;
        state_next         = state_reg;
        acc_ctrl.start_wr  = s_xfer & (s_tuser == FUNC_START);
        acc_ctrl.pass_load = s_xfer & (s_tuser == FUNC_STOP);
        case (state_reg)
            ST_IDLE: begin
                if (acc_ctrl.pass_load) begin
                    state_next = ST_SERIAL;
                end
            end
            ST_SERIAL: begin
                acc_ctrl.pass_step = 1'b1;
                if (bit_cnt_reg == LAST_BIT) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                acc_ctrl.pass_end = 1'b1;
                state_next        = ST_DIVLOAD;
            end
            ST_DIVLOAD: begin
                div_ctrl.load = 1'b1;
                state_next    = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                div_ctrl.step = 1'b1;
                if (bit_cnt_reg == LAST_BIT) begin
                    state_next = ST_OUTPUT;
                end
            end
            ST_OUTPUT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            bit_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (acc_ctrl.pass_step || div_ctrl.step) begin
                bit_cnt_reg <= bit_cnt_reg + 1'b1;
            end else begin
                bit_cnt_reg <= '0;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {OUT_TIME_W'(dur), OUT_COUNT_W'(count_val), OUT_TIME_W'(max_val),
                            OUT_TIME_W'(min_val), OUT_TIME_W'(quotient)};
            m_tuser_reg <= ovf;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    dstat_acc u_acc (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (acc_ctrl),
        .stamp     (stamp),
        .dur       (dur),
        .min_val   (min_val),
        .max_val   (max_val),
        .sum_val   (sum_val),
        .count_val (count_val),
        .ovf       (ovf)
    );

    dstat_div u_div (
        .aclk     (aclk),
        .ctrl     (div_ctrl),
        .dividend (sum_val),
        .divisor  (count_val),
        .quotient (quotient)
    );

endmodule

// ===== rtl/dstat_acc.sv =====
// bit-serial duration subtract, min/max compare and saturating sum/count update
module dstat_acc (
    input  logic               aclk,
    input  logic               aresetn,
    input  dstat_pkg::acc_ctrl_t ctrl,
    input  dstat_pkg::time_t   stamp,
    output dstat_pkg::time_t   dur,
    output dstat_pkg::time_t   min_val,
    output dstat_pkg::time_t   max_val,
    output dstat_pkg::time_t   sum_val,
    output dstat_pkg::count_t  count_val,
    output logic               ovf
);
    import dstat_pkg::*;

    time_t  start_reg;
    time_t  stamp_sh_reg;
    time_t  dur_reg;
    time_t  min_reg;
    time_t  max_reg;
    time_t  sum_reg;
    count_t count_reg;
    logic   ovf_reg;
    logic   borrow_reg;
    logic   carry_reg;
    logic   gt_max_reg;
    logic   lt_min_reg;

    logic s_bit;
    logic t_bit;
    logic d_bit;
    logic a_bit;
    logic sum_bit;

    assign s_bit   = stamp_sh_reg[0];
    assign t_bit   = start_reg[0];
    assign d_bit   = s_bit ^ t_bit ^ borrow_reg;
    assign a_bit   = sum_reg[0];
    assign sum_bit = a_bit ^ d_bit ^ carry_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg  <= '0;
            min_reg    <= '1;
            max_reg    <= '0;
            sum_reg    <= '0;
            count_reg  <= '0;
            ovf_reg    <= 1'b0;
            borrow_reg <= 1'b0;
            carry_reg  <= 1'b0;
            gt_max_reg <= 1'b0;
            lt_min_reg <= 1'b0;
        end else begin
            if (ctrl.start_wr) begin
                start_reg <= stamp;
            end
            if (ctrl.pass_load) begin
                borrow_reg <= 1'b0;
                carry_reg  <= 1'b0;
                gt_max_reg <= 1'b0;
                lt_min_reg <= 1'b0;
            end
            if (ctrl.pass_step) begin
                // lsb first; start, max and min rotate back into place after a full pass, sum becomes the new sum
                start_reg  <= {t_bit, start_reg[TIME_WIDTH-1:1]};
                borrow_reg <= (~s_bit & t_bit) | (~(s_bit ^ t_bit) & borrow_reg);
                sum_reg    <= {sum_bit, sum_reg[TIME_WIDTH-1:1]};
                carry_reg  <= (a_bit & d_bit) | (carry_reg & (a_bit ^ d_bit));
                max_reg    <= {max_reg[0], max_reg[TIME_WIDTH-1:1]};
                min_reg    <= {min_reg[0], min_reg[TIME_WIDTH-1:1]};
                if (d_bit != max_reg[0]) begin
                    gt_max_reg <= d_bit;
                end
                if (d_bit != min_reg[0]) begin
                    lt_min_reg <= ~d_bit;
                end
            end
            if (ctrl.pass_end) begin
                if (gt_max_reg) begin
                    max_reg <= dur_reg;
                end
                if (lt_min_reg) begin
                    min_reg <= dur_reg;
                end
                if (carry_reg) begin
                    sum_reg <= '1;
                end
                if (carry_reg || (count_reg == '1)) begin
                    ovf_reg <= 1'b1;
                end
                if (count_reg != '1) begin
                    count_reg <= count_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.pass_load) begin
            stamp_sh_reg <= stamp;
        end else if (ctrl.pass_step) begin
            stamp_sh_reg <= {1'b0, stamp_sh_reg[TIME_WIDTH-1:1]};
        end
        if (ctrl.pass_step) begin
            dur_reg <= {d_bit, dur_reg[TIME_WIDTH-1:1]};
        end
    end

    assign dur       = dur_reg;
    assign min_val   = min_reg;
    assign max_val   = max_reg;
    assign sum_val   = sum_reg;
    assign count_val = count_reg;
    assign ovf       = ovf_reg;

endmodule

// ===== rtl/dstat_div.sv =====
// restoring divider, one quotient bit per cycle
module dstat_div (
    input  logic                 aclk,
    input  dstat_pkg::div_ctrl_t ctrl,
    input  dstat_pkg::time_t     dividend,
    input  dstat_pkg::count_t    divisor,
    output dstat_pkg::time_t     quotient
);
    import dstat_pkg::*;

    count_t rem_reg;
    time_t  dq_reg;
    count_t dvs_reg;

    logic [COUNT_WIDTH+1:0] trial;

    assign trial = {1'b0, rem_reg, dq_reg[TIME_WIDTH-1]} - {2'b00, dvs_reg};

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            rem_reg <= '0;
            dq_reg  <= dividend;
            dvs_reg <= divisor;
        end else if (ctrl.step) begin
            if (!trial[COUNT_WIDTH+1]) begin
                rem_reg <= trial[COUNT_WIDTH-1:0];
                dq_reg  <= {dq_reg[TIME_WIDTH-2:0], 1'b1};
            end else begin
                rem_reg <= {rem_reg[COUNT_WIDTH-2:0], dq_reg[TIME_WIDTH-1]};
                dq_reg  <= {dq_reg[TIME_WIDTH-2:0], 1'b0};
            end
        end
    end

    assign quotient = dq_reg;

endmodule

// ===== rtl/dstat_checker.sv =====
// port-level checks for the duration statistics core, bound to the top level
module dstat_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [dstat_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                            m_tuser
);
    import dstat_pkg::*;

    logic [OUT_TIME_W-1:0]  mean_f;
    logic [OUT_TIME_W-1:0]  min_f;
    logic [OUT_TIME_W-1:0]  max_f;
    logic [OUT_COUNT_W-1:0] samples_f;
    logic [OUT_TIME_W-1:0]  last_f;

    assign mean_f    = m_tdata[OUT_TIME_W-1:0];
    assign min_f     = m_tdata[2*OUT_TIME_W-1:OUT_TIME_W];
    assign max_f     = m_tdata[3*OUT_TIME_W-1:2*OUT_TIME_W];
    assign samples_f = m_tdata[3*OUT_TIME_W+OUT_COUNT_W-1:3*OUT_TIME_W];
    assign last_f    = m_tdata[M_TDATA_W-1:3*OUT_TIME_W+OUT_COUNT_W];

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> samples_f != '0 && min_f <= last_f && max_f >= last_f)
        else $error("last duration outside min/max or zero count");

    a_mean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> min_f <= mean_f && mean_f <= max_f)
        else $error("mean outside min/max without saturation");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared without a busy cycle before it");

endmodule

bind duration_min_max_mean_stats_core dstat_checker u_dstat_checker (.*);

// ===== test/duration_min_max_mean_stats_core_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the duration min/max/mean statistics core
module duration_min_max_mean_stats_core_tb;
    import dstat_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int CALM_TAIL   = 150;

    typedef struct packed {
        logic  kind;
        time_t stamp;
    } mark_t;

    typedef struct packed {
        time_t  mean;
        time_t  min;
        time_t  max;
        count_t samples;
        time_t  last;
        logic   saturated;
    } stats_t;

    logic                   aclk;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata  = '0;   // timestamp
    logic                   s_tuser  = 1'b0; // func
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;         // mean, min, max, samples, last
    logic                   m_tuser;         // saturated

    duration_min_max_mean_stats_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    mark_t  marks_to_send[$];
    stats_t stats_due[$];
    mark_t  on_bus;
    time_t  gen_start = '0;

    time_t  held_start = '0;
    time_t  run_min    = '1;
    time_t  run_max    = '0;
    time_t  run_sum    = '0;
    count_t run_count  = '0;
    logic   run_sat    = 1'b0;

    int gap_cnt      = 0;
    int hold_cnt     = 0;
    bit stall_done   = 0;
    int starts_sent  = 0;
    int stops_sent   = 0;
    int results_seen = 0;
    int sat_seen     = 0;
    int error_cnt    = 0;
    int cycle_cnt    = 0;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic time_t rand_stamp();
        return {$urandom, $urandom};
    endfunction

    function automatic time_t rand_span(int lo_bits, int hi_bits);
        time_t v;
        v = rand_stamp();
        return v >> (64 - $urandom_range(lo_bits, hi_bits));
    endfunction

    function automatic void push_mark(logic kind, time_t stamp);
        mark_t m;
        m.kind  = kind;
        m.stamp = stamp;
        if (kind == FUNC_START) begin
            gen_start = stamp;
        end
        marks_to_send.push_back(m);
    endfunction

    function automatic void update_duration_stats(mark_t m);
        time_t       dur;
        logic [64:0] wide_sum;
        stats_t      r;
        if (m.kind == FUNC_START) begin
            held_start = m.stamp;
            return;
        end
        dur = m.stamp - held_start;
        if (dur > run_max) begin
            run_max = dur;
        end
        if (dur < run_min) begin
            run_min = dur;
        end
        wide_sum = {1'b0, run_sum} + {1'b0, dur};
        if (wide_sum[64]) begin
            run_sum = '1;
            run_sat = 1'b1;
        end else begin
            run_sum = wide_sum[63:0];
        end
        if (run_count == '1) begin
            run_sat = 1'b1;
        end else begin
            run_count = run_count + 1'b1;
        end
        r.mean      = run_sum / {32'b0, run_count};
        r.min       = run_min;
        r.max       = run_max;
        r.samples   = run_count;
        r.last      = dur;
        r.saturated = run_sat;
        stats_due.push_back(r);
    endfunction

    // sender
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                update_duration_stats(on_bus);
                if (on_bus.kind == FUNC_STOP) begin
                    stops_sent++;
                end else begin
                    starts_sent++;
                end
            end
            if (!s_tvalid || s_tready) begin
                if (gap_cnt != 0) begin
                    gap_cnt--;
                    s_tvalid <= 1'b0;
                end else if (marks_to_send.size() >= CALM_TAIL
                             && ((starts_sent + stops_sent) / 48) % 4 != 3
                             && $urandom_range(0, 5) == 0) begin
                    gap_cnt  = $urandom_range(0, 15);
                    s_tvalid <= 1'b0;
                end else if (marks_to_send.size() != 0) begin
                    on_bus = marks_to_send.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= on_bus.stamp;
                    s_tuser  <= on_bus.kind;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge aclk) begin
        stats_t got;
        stats_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.mean      = m_tdata[0 +: 64];
                got.min       = m_tdata[64 +: 64];
                got.max       = m_tdata[128 +: 64];
                got.samples   = m_tdata[192 +: 32];
                got.last      = m_tdata[224 +: 64];
                got.saturated = m_tuser;
                results_seen++;
                if (got.saturated) begin
                    sat_seen++;
                end
                if (stats_due.size() == 0) begin
                    error_cnt++;
                    if (error_cnt <= 10) begin
                        $display("%0t: result transfer with none expected: mean %h last %h",
                                 $realtime, got.mean, got.last);
                    end
                end else begin
                    want = stats_due.pop_front();
                    if (got !== want) begin
                        error_cnt++;
                        if (error_cnt <= 10) begin
                            $display("%0t: mismatch on result %0d", $realtime, results_seen);
                            $display("  mean exp %h got %h  last exp %h got %h",
                                     want.mean, got.mean, want.last, got.last);
                            $display("  min  exp %h got %h  max  exp %h got %h",
                                     want.min, got.min, want.max, got.max);
                            $display("  samples exp %0d got %0d  saturated exp %b got %b",
                                     want.samples, got.samples, want.saturated,
                                     got.saturated);
                        end
                    end
                end
            end
            if (hold_cnt != 0) begin
                hold_cnt--;
                m_tready <= 1'b0;
            end else if (!stall_done && results_seen == 40) begin
                // long back-pressure so the core fills up and drops s_tready
                stall_done = 1;
                hold_cnt   = 1499;
                m_tready   <= 1'b0;
            end else if (marks_to_send.size() >= CALM_TAIL
                         && (results_seen / 16) % 4 != 3
                         && $urandom_range(0, 4) == 0) begin
                hold_cnt = $urandom_range(0, 15);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still due",
                     cycle_cnt, stats_due.size());
            $display("duration_min_max_mean_stats_core_tb: FAIL");
            $finish;
        end
    end

    initial begin
        time_t base;
        int    pick;
        int    nstops;

        // directed: stop with no start, wrap, several stops per start, bit patterns
        push_mark(FUNC_STOP, 64'd1000);
        push_mark(FUNC_START, 64'd0);
        push_mark(FUNC_STOP, 64'd500);
        push_mark(FUNC_START, '1);
        push_mark(FUNC_STOP, 64'd5);
        push_mark(FUNC_START, 64'h8000_0000_0000_0000);
        push_mark(FUNC_STOP, 64'h8000_0000_0000_0007);
        push_mark(FUNC_STOP, 64'h8000_0000_0000_0064);
        push_mark(FUNC_STOP, 64'h8000_0000_0000_0002);
        push_mark(FUNC_START, 64'hFFFF_FFFF_FFFF_FF00);
        push_mark(FUNC_START, 64'h1234);
        push_mark(FUNC_STOP, 64'h1234 + 64'd300);
        push_mark(FUNC_START, 64'hAAAA_AAAA_AAAA_AAAA);
        push_mark(FUNC_STOP, 64'hAAAA_AAAA_AAAA_FFFF);
        push_mark(FUNC_START, 64'h5555_5555_5555_5555);
        push_mark(FUNC_STOP, 64'h5555_5555_5555_5556);

        // random: durations kept below 2^54 so the sum stays exact for a long time
        while (marks_to_send.size() < 1000) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                base = rand_stamp();
                push_mark(FUNC_START, base);
                nstops = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 4) : 1;
                repeat (nstops) push_mark(FUNC_STOP, base + rand_span(8, 54));
            end else if (pick < 85) begin
                push_mark(FUNC_START, rand_stamp());
            end else begin
                push_mark(FUNC_STOP, gen_start + rand_span(8, 54));
            end
        end

        // extremes and sum saturation; count saturation needs 2^32 stops, out of reach
        push_mark(FUNC_START, '0);
        push_mark(FUNC_STOP, '1);
        push_mark(FUNC_START, 64'd100);
        push_mark(FUNC_STOP, 64'd40);
        base = rand_stamp();
        push_mark(FUNC_START, base);
        push_mark(FUNC_STOP, base);
        repeat (40) begin
            push_mark(FUNC_START, rand_stamp());
            push_mark(FUNC_STOP, rand_stamp());
        end

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        while (marks_to_send.size() != 0 || s_tvalid) @(posedge aclk);
        while (stats_due.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);

        $display("sent %0d start and %0d stop marks, checked %0d result transfers",
                 starts_sent, stops_sent, results_seen);
        $display("%0d results flagged saturated; final min %h max %h",
                 sat_seen, run_min, run_max);
        if (error_cnt == 0) begin
            $display("duration_min_max_mean_stats_core_tb: PASS");
        end else begin
            $display("%0d errors", error_cnt);
            $display("duration_min_max_mean_stats_core_tb: FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/dstat_pkg.sv
rtl/dstat_acc.sv
rtl/dstat_div.sv
rtl/duration_min_max_mean_stats_core.sv
rtl/dstat_checker.sv
test/duration_min_max_mean_stats_core_tb.sv
